>>> rtl/dcca_pkg.sv
// Shared constants, types and helper functions of the chapter cell accumulator.
package dcca_pkg;

    localparam int SUM_W          = 48;
    localparam int RATE_W         = 40;
    localparam int SECTOR_W       = 32;
    localparam int SECTOR_SHIFT   = 11;
    localparam int CFG_W          = 16;
    localparam int SECS_W         = 20;
    localparam int SECS_US_W      = 40;
    localparam int FRAME_SCALED_W = 23;
    localparam int FRAME_US_W     = 21;
    localparam int BITS_US_W      = 23;
    localparam int NUM_W          = SUM_W + BITS_US_W;
    localparam int QUO_BITS       = 40;
    localparam int DIV_CNT_W      = 6;

    localparam logic [SECS_W-1:0]         US_PER_S        = 20'd1000000;
    localparam logic [SUM_W-1:0]          SUM_MAX         = '1;
    localparam logic [RATE_W-1:0]         RATE_MAX        = '1;
    localparam logic [RATE_W-1:0]         DEFAULT_RATE    = 40'd8388608;
    localparam logic [BITS_US_W-1:0]      BITS_US         = 23'd8000000;
    localparam logic [FRAME_SCALED_W-1:0] NTSC_FRAME_US3  = 23'd100100;
    localparam logic [FRAME_SCALED_W-1:0] PAL_FRAME_US    = 23'd40000;
    localparam logic [23:0]               RECIP3          = 24'd11184811;
    localparam int                        RECIP3_SHIFT    = 25;

    localparam logic [1:0] MODE_NOT_IN_BLOCK = 2'd0;
    localparam logic [1:0] MODE_FIRST_CELL   = 2'd1;
    localparam logic [1:0] TYPE_ANGLE        = 2'd1;
    localparam logic [1:0] RATE_CODE_NTSC    = 2'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // One classified cell, as handed from the front end to the back end.
    typedef struct packed {
        logic                  add_en;
        logic                  angle;
        logic                  chapter_end;
        logic [SECTOR_W-1:0]   sectors;
        logic [SECS_US_W-1:0]  secs_us;
        logic [FRAME_US_W-1:0] frame_us;
    } dcca_cell_t;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL,
        ST_NUM,
        ST_CHK,
        ST_DIV
    } dcca_state_t;

    // Two BCD digits to binary, no digit check.
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        return 8'(v[7:4]) * 8'd10 + 8'(v[3:0]);
    endfunction

endpackage

>>> rtl/dcca_channels.sv
// Handshake channel interfaces: cell items in, chapter results out, configuration writes.
interface dcca_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_mode;
    logic [1:0] cell_kind;
    logic [31:0] start_sector;
    logic [31:0] end_sector;
    logic [7:0] bcd_hours;
    logic [7:0] bcd_minutes;
    logic [7:0] bcd_seconds;
    logic [7:0] frame_byte;
    logic       chapter_end;

    modport source (
        output valid, cell_mode, cell_kind, start_sector, end_sector,
               bcd_hours, bcd_minutes, bcd_seconds, frame_byte, chapter_end,
        input  ready
    );
    modport sink (
        input  valid, cell_mode, cell_kind, start_sector, end_sector,
               bcd_hours, bcd_minutes, bcd_seconds, frame_byte, chapter_end,
        output ready
    );
endinterface

interface dcca_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] total_bytes;
    logic [47:0] duration_us;
    logic        angle_seen;
    logic        too_short;
    logic [39:0] bitrate_bps;

    modport source (
        output valid, total_bytes, duration_us, angle_seen, too_short, bitrate_bps,
        input  ready
    );
    modport sink (
        input  valid, total_bytes, duration_us, angle_seen, too_short, bitrate_bps,
        output ready
    );
endinterface

interface dcca_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] min_chapter_seconds;

    modport source (
        output valid, min_chapter_seconds,
        input  ready
    );
    modport sink (
        input  valid, min_chapter_seconds,
        output ready
    );
endinterface

>>> rtl/dvd_chapter_cell_accumulator_top.sv
// Top level of the DVD chapter cell accumulator: front end, cell queue and back end.
//
// Takes one DVD cell-playback record per item on cells and sums, per chapter, the cell
// size ((end_sector - start_sector) * 2048 bytes, 32 bit sector difference) and the
// BCD playback time in microseconds (25 fps frames, or 30000/1001 fps frames for rate
// code 1, frame time floored) of every cell outside an angle block or first in one.
// Any cell of block type 1 marks the chapter as having angles. The cell flagged
// chapter_end is counted, then one result item appears on chapters with both totals
// (saturating at 2^48-1), the angle flag, a too-short flag against min_chapter_seconds
// and floor(bytes * 8000000 / duration) saturating at 2^40-1, or 8388608 for a zero
// duration; the totals then restart from zero. The cfg channel is always ready and
// must be written only while the block is idle. A two-stage front end converts
// an item (input register, then the seconds and frame multipliers) and a two-entry
// queue hands it to the back end; while the back end is in its accumulate state,
// ordinary cells stream at one item per clock. A chapter-ending cell occupies the
// back end for its product step, where a zero duration ends it, then the numerator
// add and the overflow compare, where a saturating quotient ends it, then a 40-step
// restoring divider, one quotient bit per cycle; meanwhile the queue and front end
// keep taking items until they fill. The one result register decouples the chapters
// port: only the next ending cell waits for a pending result to be taken.
module dvd_chapter_cell_accumulator_top (
    input  logic        clk,
    input  logic        rst_n,
    dcca_in_if.sink     cells,
    dcca_cfg_if.sink    cfg,
    dcca_out_if.source  chapters
);

    // Front end to queue
    logic                   push_valid;
    logic                   push_ready;
    dcca_pkg::dcca_cell_t   push_cell;

    // Queue to back end
    logic                   pop_valid;
    logic                   pop_ready;
    dcca_pkg::dcca_cell_t   pop_cell;

    // Classify the item, convert BCD time and sector span
    dcca_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cells      (cells),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cell  (push_cell)
    );

    // Let front and back stall independently
    dcca_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cell  (push_cell),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cell   (pop_cell)
    );

    // Accumulate, divide on chapter end, hold the result until taken
    dcca_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cell   (pop_cell),
        .cfg        (cfg),
        .chapters   (chapters)
    );

endmodule

>>> rtl/dcca_front.sv
// Front end: accept cell items, classify them and convert sizes and BCD times.
module dcca_front (
    input  logic                    clk,
    input  logic                    rst_n,
    dcca_in_if.sink                 cells,
    output logic                    push_valid,
    input  logic                    push_ready,
    output dcca_pkg::dcca_cell_t    push_cell
);

    // Stage 1: classified item with seconds and scaled frame count
    logic                                   s1_valid_reg;
    logic                                   s1_valid_next;
    logic                                   s1_add_reg;
    logic                                   s1_angle_reg;
    logic                                   s1_end_reg;
    logic                                   s1_ntsc_reg;
    logic [dcca_pkg::SECTOR_W-1:0]          s1_sectors_reg;
    logic [dcca_pkg::SECS_W-1:0]            s1_secs_reg;
    logic [dcca_pkg::FRAME_SCALED_W-1:0]    s1_fscaled_reg;

    // Stage 2: finished cell record
    logic                                   s2_valid_reg;
    logic                                   s2_valid_next;
    dcca_pkg::dcca_cell_t                   s2_cell_reg;

    logic                                   s1_ready;
    logic                                   s2_ready;
    logic                                   take;
    logic                                   move;
    logic [7:0]                             hours;
    logic [7:0]                             minutes;
    logic [7:0]                             seconds;
    logic [7:0]                             frames;
    logic                                   ntsc;
    logic [dcca_pkg::SECS_W-1:0]            secs;
    logic [dcca_pkg::FRAME_SCALED_W-1:0]    fscaled;
    logic [dcca_pkg::SECS_US_W-1:0]         secs_us;
    logic [46:0]                            recip_prod;
    logic [dcca_pkg::FRAME_US_W-1:0]        frame_us;

    assign s2_ready    = !s2_valid_reg || push_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign move        = s1_valid_reg && s2_ready;
    assign take        = cells.valid && s1_ready;
    assign cells.ready = s1_ready;

    assign hours   = dcca_pkg::bcd_to_bin(cells.bcd_hours);
    assign minutes = dcca_pkg::bcd_to_bin(cells.bcd_minutes);
    assign seconds = dcca_pkg::bcd_to_bin(cells.bcd_seconds);
    assign frames  = dcca_pkg::bcd_to_bin({2'b00, cells.frame_byte[5:0]});
    assign ntsc    = (cells.frame_byte[7:6] == dcca_pkg::RATE_CODE_NTSC);

    assign secs = dcca_pkg::SECS_W'(hours) * 20'd3600
                + dcca_pkg::SECS_W'(minutes) * 20'd60
                + dcca_pkg::SECS_W'(seconds);

    // NTSC holds f*100100 here and is divided by three in stage 2
    assign fscaled = ntsc
        ? dcca_pkg::FRAME_SCALED_W'(frames) * dcca_pkg::NTSC_FRAME_US3
        : dcca_pkg::FRAME_SCALED_W'(frames) * dcca_pkg::PAL_FRAME_US;

    assign secs_us    = dcca_pkg::SECS_US_W'(s1_secs_reg)
                      * dcca_pkg::SECS_US_W'(dcca_pkg::US_PER_S);
    assign recip_prod = 47'(s1_fscaled_reg) * 47'(dcca_pkg::RECIP3);
    assign frame_us   = s1_ntsc_reg
        ? recip_prod[dcca_pkg::RECIP3_SHIFT +: dcca_pkg::FRAME_US_W]
        : s1_fscaled_reg[dcca_pkg::FRAME_US_W-1:0];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (move)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_add_reg     <= (cells.cell_mode == dcca_pkg::MODE_NOT_IN_BLOCK)
                           || (cells.cell_mode == dcca_pkg::MODE_FIRST_CELL);
            s1_angle_reg   <= (cells.cell_kind == dcca_pkg::TYPE_ANGLE);
            s1_end_reg     <= cells.chapter_end;
            s1_ntsc_reg    <= ntsc;
            s1_sectors_reg <= cells.end_sector - cells.start_sector;
            s1_secs_reg    <= secs;
            s1_fscaled_reg <= fscaled;
        end
        if (move)
        begin
            s2_cell_reg.add_en      <= s1_add_reg;
            s2_cell_reg.angle       <= s1_angle_reg;
            s2_cell_reg.chapter_end <= s1_end_reg;
            s2_cell_reg.sectors     <= s1_sectors_reg;
            s2_cell_reg.secs_us     <= secs_us;
            s2_cell_reg.frame_us    <= frame_us;
        end
    end

    assign push_valid = s2_valid_reg;
    assign push_cell  = s2_cell_reg;

endmodule

>>> rtl/dcca_queue.sv
// Short cell queue between the front end and the back end.
module dcca_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  dcca_pkg::dcca_cell_t    push_cell,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output dcca_pkg::dcca_cell_t    pop_cell
);

    dcca_pkg::dcca_cell_t               entry_reg [dcca_pkg::QUEUE_DEPTH];
    logic [dcca_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [dcca_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [dcca_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [dcca_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [dcca_pkg::QPTR_W:0]          count_reg;
    logic [dcca_pkg::QPTR_W:0]          count_next;
    logic                               push;
    logic                               pop;

    assign push_ready = (count_reg != (dcca_pkg::QPTR_W+1)'(dcca_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cell   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dcca_pkg::QPTR_W'(dcca_pkg::QUEUE_DEPTH-1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dcca_pkg::QPTR_W'(dcca_pkg::QUEUE_DEPTH-1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cell;
        end
    end

endmodule

>>> rtl/dcca_back.sv
// Back end: accumulate chapter totals, run the bitrate divider, hold the result.
module dcca_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  dcca_pkg::dcca_cell_t    pop_cell,
    dcca_cfg_if.sink                cfg,
    dcca_out_if.source              chapters
);

    dcca_pkg::dcca_state_t              state_reg;
    dcca_pkg::dcca_state_t              state_next;

    logic [dcca_pkg::SUM_W-1:0]         byte_sum_reg;
    logic [dcca_pkg::SUM_W-1:0]         byte_sum_next;
    logic [dcca_pkg::SUM_W-1:0]         time_sum_reg;
    logic [dcca_pkg::SUM_W-1:0]         time_sum_next;
    logic                               angle_reg;
    logic                               angle_next;
    logic [dcca_pkg::CFG_W-1:0]         min_secs_reg;

    // Finished chapter totals; these also drive the result port
    logic [dcca_pkg::SUM_W-1:0]         bytes_reg;
    logic [dcca_pkg::SUM_W-1:0]         bytes_next;
    logic [dcca_pkg::SUM_W-1:0]         dur_reg;
    logic [dcca_pkg::SUM_W-1:0]         dur_next;
    logic                               angle_res_reg;
    logic                               angle_res_next;
    logic                               short_reg;
    logic                               short_next;
    logic [dcca_pkg::RATE_W-1:0]        rate_reg;
    logic [dcca_pkg::RATE_W-1:0]        rate_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    // Divider datapath
    logic [54:0]                        pl_reg;
    logic [54:0]                        pl_next;
    logic [38:0]                        ph_reg;
    logic [38:0]                        ph_next;
    logic [dcca_pkg::NUM_W-1:0]         num_reg;
    logic [dcca_pkg::NUM_W-1:0]         num_next;
    logic [dcca_pkg::SUM_W-1:0]         rem_reg;
    logic [dcca_pkg::SUM_W-1:0]         rem_next;
    logic [dcca_pkg::QUO_BITS-1:0]      low_reg;
    logic [dcca_pkg::QUO_BITS-1:0]      low_next;
    logic [dcca_pkg::QUO_BITS-1:0]      quo_reg;
    logic [dcca_pkg::QUO_BITS-1:0]      quo_next;
    logic [dcca_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [dcca_pkg::DIV_CNT_W-1:0]     cnt_next;

    logic                               pop;
    logic [dcca_pkg::SUM_W:0]           bsum_wide;
    logic [dcca_pkg::SUM_W+1:0]         tsum_wide;
    logic [dcca_pkg::SUM_W-1:0]         bsum_new;
    logic [dcca_pkg::SUM_W-1:0]         tsum_new;
    logic                               angle_new;
    logic [35:0]                        min_us;
    logic                               short_comb;
    logic [dcca_pkg::SUM_W-1:0]         num_top;
    logic [dcca_pkg::SUM_W:0]           trial;
    logic                               qbit;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_secs_reg <= '0;
        end
        else if (cfg.valid)
        begin
            min_secs_reg <= cfg.min_chapter_seconds;
        end
    end

    // Hold an ending cell back while the previous result still waits
    assign pop = (state_reg == dcca_pkg::ST_ACC) && pop_valid
              && (!pop_cell.chapter_end || !out_valid_reg);
    assign pop_ready = pop;

    assign bsum_wide = {1'b0, byte_sum_reg}
                     + (dcca_pkg::SUM_W+1)'({pop_cell.sectors, {dcca_pkg::SECTOR_SHIFT{1'b0}}});
    assign tsum_wide = (dcca_pkg::SUM_W+2)'(time_sum_reg)
                     + (dcca_pkg::SUM_W+2)'(pop_cell.secs_us)
                     + (dcca_pkg::SUM_W+2)'(pop_cell.frame_us);

    always_comb
    begin
        bsum_new = byte_sum_reg;
        tsum_new = time_sum_reg;
        if (pop_cell.add_en)
        begin
            bsum_new = bsum_wide[dcca_pkg::SUM_W] ? dcca_pkg::SUM_MAX
                                                  : bsum_wide[dcca_pkg::SUM_W-1:0];
            tsum_new = (|tsum_wide[dcca_pkg::SUM_W+1:dcca_pkg::SUM_W]) ? dcca_pkg::SUM_MAX
                                                  : tsum_wide[dcca_pkg::SUM_W-1:0];
        end
    end

    assign angle_new  = angle_reg || pop_cell.angle;
    assign min_us     = 36'(min_secs_reg) * 36'(dcca_pkg::US_PER_S);
    assign short_comb = (dur_reg < dcca_pkg::SUM_W'(min_us));
    assign num_top    = dcca_pkg::SUM_W'(num_reg[dcca_pkg::NUM_W-1:dcca_pkg::QUO_BITS]);
    assign trial      = {rem_reg, low_reg[dcca_pkg::QUO_BITS-1]};
    assign qbit       = (trial >= {1'b0, dur_reg});

    always_comb
    begin
        state_next     = state_reg;
        byte_sum_next  = byte_sum_reg;
        time_sum_next  = time_sum_reg;
        angle_next     = angle_reg;
        bytes_next     = bytes_reg;
        dur_next       = dur_reg;
        angle_res_next = angle_res_reg;
        short_next     = short_reg;
        rate_next      = rate_reg;
        out_valid_next = out_valid_reg && !chapters.ready;
        pl_next        = pl_reg;
        ph_next        = ph_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;

        case (state_reg)
            dcca_pkg::ST_ACC:
            begin
                if (pop)
                begin
                    if (pop_cell.chapter_end)
                    begin
                        bytes_next     = bsum_new;
                        dur_next       = tsum_new;
                        angle_res_next = angle_new;
                        byte_sum_next  = '0;
                        time_sum_next  = '0;
                        angle_next     = 1'b0;
                        state_next     = dcca_pkg::ST_MUL;
                    end
                    else
                    begin
                        byte_sum_next = bsum_new;
                        time_sum_next = tsum_new;
                        angle_next    = angle_new;
                    end
                end
            end
            dcca_pkg::ST_MUL:
            begin
                pl_next    = 55'(bytes_reg[31:0]) * 55'(dcca_pkg::BITS_US);
                ph_next    = 39'(bytes_reg[dcca_pkg::SUM_W-1:32]) * 39'(dcca_pkg::BITS_US);
                short_next = short_comb;
                if (dur_reg == '0)
                begin
                    rate_next      = dcca_pkg::DEFAULT_RATE;
                    out_valid_next = 1'b1;
                    state_next     = dcca_pkg::ST_ACC;
                end
                else
                begin
                    state_next = dcca_pkg::ST_NUM;
                end
            end
            dcca_pkg::ST_NUM:
            begin
                num_next   = {ph_reg, 32'd0} + dcca_pkg::NUM_W'(pl_reg);
                state_next = dcca_pkg::ST_CHK;
            end
            dcca_pkg::ST_CHK:
            begin
                // Quotient of 2^40 or more saturates
                if (num_top >= dur_reg)
                begin
                    rate_next      = dcca_pkg::RATE_MAX;
                    out_valid_next = 1'b1;
                    state_next     = dcca_pkg::ST_ACC;
                end
                else
                begin
                    rem_next   = num_top;
                    low_next   = num_reg[dcca_pkg::QUO_BITS-1:0];
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = dcca_pkg::ST_DIV;
                end
            end
            dcca_pkg::ST_DIV:
            begin
                rem_next = qbit ? dcca_pkg::SUM_W'(trial - {1'b0, dur_reg})
                                : trial[dcca_pkg::SUM_W-1:0];
                low_next = {low_reg[dcca_pkg::QUO_BITS-2:0], 1'b0};
                quo_next = {quo_reg[dcca_pkg::QUO_BITS-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == dcca_pkg::DIV_CNT_W'(dcca_pkg::QUO_BITS-1))
                begin
                    rate_next      = {quo_reg[dcca_pkg::QUO_BITS-2:0], qbit};
                    out_valid_next = 1'b1;
                    state_next     = dcca_pkg::ST_ACC;
                end
            end
            default:
            begin
                state_next = dcca_pkg::ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcca_pkg::ST_ACC;
            byte_sum_reg  <= '0;
            time_sum_reg  <= '0;
            angle_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_sum_reg  <= byte_sum_next;
            time_sum_reg  <= time_sum_next;
            angle_reg     <= angle_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg     <= bytes_next;
        dur_reg       <= dur_next;
        angle_res_reg <= angle_res_next;
        short_reg     <= short_next;
        rate_reg      <= rate_next;
        pl_reg        <= pl_next;
        ph_reg        <= ph_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        low_reg       <= low_next;
        quo_reg       <= quo_next;
    end

    assign chapters.valid       = out_valid_reg;
    assign chapters.total_bytes = bytes_reg;
    assign chapters.duration_us = dur_reg;
    assign chapters.angle_seen  = angle_res_reg;
    assign chapters.too_short   = short_reg;
    assign chapters.bitrate_bps = rate_reg;

    // An ending cell never overwrites a result that is still waiting
    a_end_waits_for_output: assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_cell.chapter_end |-> !out_valid_reg)
        else $error("ending cell taken while a result is pending");

    // Totals start from zero after a chapter closes
    a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_cell.chapter_end |=> byte_sum_reg == '0 && time_sum_reg == '0 && !angle_reg)
        else $error("accumulators not cleared after chapter end");

    // A result appears only from the bitrate sequence states, never straight from accumulation
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) != dcca_pkg::ST_ACC)
        else $error("result raised outside the bitrate sequence");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dcca_pkg::ST_DIV |-> rem_reg < dur_reg)
        else $error("divider remainder out of range");

endmodule
